### rtl/core/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Widths and fixed-point constants for the HSL to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int HueFractionBits   = 6;
  localparam int LevelFractionBits = 8;

  localparam int HueW   = 15;
  localparam int LevelW = 9;
  localparam int ChanW  = 8;
  localparam int ChanMax = (1 << ChanW) - 1;

  localparam int LevelOne = 1 << LevelFractionBits;
  localparam int HueTurn  = 360 << HueFractionBits;
  localparam int HueThird = HueTurn / 3;

  // hue position within one turn
  localparam int PosW    = $clog2(HueTurn);
  localparam int HueExtW = ((HueW > PosW) ? HueW : PosW) + 1;
  localparam int SixW    = PosW + 3;

  // chroma levels over LevelOne squared
  localparam int VW    = 2 * LevelFractionBits + 1;
  localparam int CalcW = VW + 1;
  localparam int MulW  = 2 * LevelW;

  // channel numerator and final scaling
  localparam int NumW   = VW + PosW;
  localparam int ScaleW = NumW + ChanW;
  localparam int DropW  = 2 * LevelFractionBits + HueFractionBits + 3;
  localparam int YW     = ScaleW - DropW;

  // turn = HueDiv << (HueFractionBits + 3), division by HueDiv via reciprocal
  localparam int HueDiv     = HueTurn >> (HueFractionBits + 3);
  localparam int RecipShift = YW + $clog2(HueDiv);
  localparam int RecipMul   = ((1 << RecipShift) + HueDiv - 1) / HueDiv;
  localparam int RecipW     = $clog2(RecipMul + 1);
  localparam int RprodW     = YW + RecipW;
  localparam int QW         = RprodW - RecipShift;

  localparam int GreyW = LevelW + ChanW;

  localparam int NumChan = 3;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [VW-1:0]    level_t;
  typedef logic [NumW-1:0]  num_t;
  typedef logic [ChanW-1:0] chan_t;

endpackage

### rtl/core/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to 8-bit RGB pixel converter, five-stage pipeline, one pixel per clock.
// ----------------------------------------------------------------------------
// A pixel beat is taken at a rising edge where start_i is high and busy_o is
// low; busy_o is tied low, so a new pixel can be taken at every edge.
// hue_i is degrees with HueFractionBits fraction bits, saturation_i and
// lightness_i count LevelOne as 1.0 and are saturated to it.
// The result appears on red_o, green_o and blue_o with done_o high for exactly
// one cycle, once the pixel has passed the five registered stages below.
// The stages are: level clamp and hue wrap; chroma levels, channel hue
// offsets and grey level; segment pick and level-times-turn products;
// scaling by 255 and the shift part of the division by one turn;
// reciprocal multiply for the remaining division by 45, clamp and grey select.
// Reset clears the valid bits of every stage, so no result appears after it.
// The receiver cannot stall; each result beat is taken in its one cycle.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [hsl2rgb_pkg::HueW-1:0]    hue_i,
  input  logic [hsl2rgb_pkg::LevelW-1:0]  saturation_i,
  input  logic [hsl2rgb_pkg::LevelW-1:0]  lightness_i,
  output logic                            done_o,
  output logic [hsl2rgb_pkg::ChanW-1:0]   red_o,
  output logic [hsl2rgb_pkg::ChanW-1:0]   green_o,
  output logic [hsl2rgb_pkg::ChanW-1:0]   blue_o
);
  import hsl2rgb_pkg::*;

  // stage 1 signals
  logic [LevelW-1:0]  sat_d, lit_d;
  logic [HueExtW-1:0] hue_ext;
  pos_t               pos_d;
  logic               vld1_q;
  logic [LevelW-1:0]  sat1_q, lit1_q;
  pos_t               pos1_q;

  // stage 2 signals
  logic [MulW-1:0]   ls_prod;
  logic [CalcW-1:0]  lit_sh, sat_sh, v2_calc;
  level_t            v1_d, v2_d, span_d;
  logic [PosW:0]     red_sum;
  pos_t              x_d [NumChan];
  logic [GreyW-1:0]  grey_calc;
  chan_t             grey_d;
  logic              vld2_q;
  level_t            v1_2_q, v2_2_q, span2_q;
  pos_t              x2_q [NumChan];
  chan_t             grey2_q;
  logic              zero2_q;

  // stage 3 signals
  logic [SixW-1:0]   six_x [NumChan];
  level_t            base_c [NumChan];
  pos_t              f_c [NumChan];
  num_t              base_d [NumChan];
  num_t              spf_d [NumChan];
  logic              vld3_q;
  num_t              base3_q [NumChan];
  num_t              spf3_q [NumChan];
  chan_t             grey3_q;
  logic              zero3_q;

  // stage 4 signals
  num_t              num_c [NumChan];
  logic [ScaleW-1:0] scaled_c [NumChan];
  logic [YW-1:0]     y_d [NumChan];
  logic              vld4_q;
  logic [YW-1:0]     y4_q [NumChan];
  chan_t             grey4_q;
  logic              zero4_q;

  // stage 5 signals
  logic [RprodW-1:0] rprod [NumChan];
  logic [QW-1:0]     quo [NumChan];
  chan_t             chan_d [NumChan];
  logic              done_q;
  chan_t             red_q, green_q, blue_q;

  // stage 1: clamp levels, wrap hue into one turn
  always_comb begin
    sat_d = saturation_i;
    lit_d = lightness_i;
    if (int'(saturation_i) > LevelOne) begin
      sat_d = LevelW'(LevelOne);
    end
    if (int'(lightness_i) > LevelOne) begin
      lit_d = LevelW'(LevelOne);
    end
    hue_ext = HueExtW'(hue_i);
    if (hue_ext >= HueExtW'(HueTurn)) begin
      pos_d = PosW'(hue_ext - HueExtW'(HueTurn));
    end else begin
      pos_d = PosW'(hue_ext);
    end
  end

  // stage 2: chroma levels, channel hue offsets, grey level
  always_comb begin
    ls_prod = MulW'(sat1_q) * MulW'(lit1_q);
    lit_sh  = CalcW'(lit1_q) << LevelFractionBits;
    sat_sh  = CalcW'(sat1_q) << LevelFractionBits;
    if ((int'(lit1_q) * 2) < LevelOne) begin
      v2_calc = lit_sh + CalcW'(ls_prod);
    end else begin
      v2_calc = lit_sh + sat_sh - CalcW'(ls_prod);
    end
    v2_d   = VW'(v2_calc);
    v1_d   = VW'((lit_sh << 1) - CalcW'(v2_d));
    span_d = v2_d - v1_d;

    red_sum = (PosW + 1)'(pos1_q) + (PosW + 1)'(HueThird);
    if (red_sum >= (PosW + 1)'(HueTurn)) begin
      x_d[0] = PosW'(red_sum - (PosW + 1)'(HueTurn));
    end else begin
      x_d[0] = PosW'(red_sum);
    end
    x_d[1] = pos1_q;
    if (pos1_q >= PosW'(HueThird)) begin
      x_d[2] = pos1_q - PosW'(HueThird);
    end else begin
      x_d[2] = pos1_q + PosW'(HueTurn - HueThird);
    end

    grey_calc = ((GreyW'(lit1_q) << ChanW) - GreyW'(lit1_q)) >> LevelFractionBits;
    if (grey_calc > GreyW'(ChanMax)) begin
      grey_d = ChanW'(ChanMax);
    end else begin
      grey_d = ChanW'(grey_calc);
    end
  end

  // stage 3: segment pick and products
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      six_x[c] = SixW'(x2_q[c]) * SixW'(6);
      if (six_x[c] < SixW'(HueTurn)) begin
        base_c[c] = v1_2_q;
        f_c[c]    = PosW'(six_x[c]);
      end else if ((SixW'(x2_q[c]) << 1) < SixW'(HueTurn)) begin
        base_c[c] = v2_2_q;
        f_c[c]    = '0;
      end else if ((SixW'(x2_q[c]) * SixW'(3)) < SixW'(2 * HueTurn)) begin
        base_c[c] = v1_2_q;
        f_c[c]    = PosW'(SixW'(4 * HueTurn) - six_x[c]);
      end else begin
        base_c[c] = v1_2_q;
        f_c[c]    = '0;
      end
      base_d[c] = NumW'(base_c[c]) * NumW'(HueTurn);
      spf_d[c]  = NumW'(span2_q) * NumW'(f_c[c]);
    end
  end

  // stage 4: sum, times 255, drop the power-of-two part of the divisor
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      num_c[c]    = base3_q[c] + spf3_q[c];
      scaled_c[c] = (ScaleW'(num_c[c]) << ChanW) - ScaleW'(num_c[c]);
      y_d[c]      = YW'(scaled_c[c] >> DropW);
    end
  end

  // stage 5: reciprocal divide, clamp, grey select
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rprod[c] = RprodW'(y4_q[c]) * RprodW'(RecipMul);
      quo[c]   = QW'(rprod[c] >> RecipShift);
      if (zero4_q) begin
        chan_d[c] = grey4_q;
      end else if (quo[c] > QW'(ChanMax)) begin
        chan_d[c] = ChanW'(ChanMax);
      end else begin
        chan_d[c] = ChanW'(quo[c]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= start_i & ~busy_o;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      done_q <= vld4_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    sat1_q  <= sat_d;
    lit1_q  <= lit_d;
    pos1_q  <= pos_d;

    v1_2_q  <= v1_d;
    v2_2_q  <= v2_d;
    span2_q <= span_d;
    x2_q    <= x_d;
    grey2_q <= grey_d;
    zero2_q <= (sat1_q == '0);

    base3_q <= base_d;
    spf3_q  <= spf_d;
    grey3_q <= grey2_q;
    zero3_q <= zero2_q;

    y4_q    <= y_d;
    grey4_q <= grey3_q;
    zero4_q <= zero3_q;

    red_q   <= chan_d[0];
    green_q <= chan_d[1];
    blue_q  <= chan_d[2];
  end

  assign busy_o  = 1'b0;
  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
